@@ design/fslu_pkg.sv @@
package fslu_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int WIDTH_W   = 7;
    localparam int ACTION_W  = 4;
    localparam int SCALAR_W  = 2;

    localparam logic [MAX_WIDTH-1:0] ALL_ONES  = {MAX_WIDTH{1'b1}};
    localparam logic [MAX_WIDTH-1:0] ALL_ZEROS = {MAX_WIDTH{1'b0}};

    // action codes
    localparam logic [ACTION_W-1:0] ACT_NOT   = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_AND   = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_OR    = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_XOR   = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_MERGE = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_RAND  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_RNAND = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_ROR   = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_RNOR  = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_RXOR  = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_RXNOR = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_SHL   = 4'd11;
    localparam logic [ACTION_W-1:0] ACT_SHR   = 4'd12;
    localparam logic [ACTION_W-1:0] ACT_ASHR  = 4'd13;

    // scalar result codes
    localparam logic [SCALAR_W-1:0] SC_ZERO = 2'd0;
    localparam logic [SCALAR_W-1:0] SC_ONE  = 2'd1;
    localparam logic [SCALAR_W-1:0] SC_X    = 2'd2;

    // dual-rail vector: zero rail / one rail
    typedef struct packed {
        logic [MAX_WIDTH-1:0] zero;
        logic [MAX_WIDTH-1:0] one;
    } rail_t;

endpackage

@@ design/fslu_in_if.sv @@
interface fslu_in_if;
    logic                           valid;
    logic                           ready;
    logic [fslu_pkg::ACTION_W-1:0]  action;
    logic [fslu_pkg::MAX_WIDTH-1:0] a_zero_rail;
    logic [fslu_pkg::MAX_WIDTH-1:0] a_one_rail;
    logic [fslu_pkg::MAX_WIDTH-1:0] b_zero_rail;
    logic [fslu_pkg::MAX_WIDTH-1:0] b_one_rail;
    logic [fslu_pkg::WIDTH_W-1:0]   vec_width;
    logic [fslu_pkg::WIDTH_W-1:0]   shift_amount;
    logic                           shift_unknown;
    logic                           a_signed_negative;

    modport source (
        output valid, action, a_zero_rail, a_one_rail, b_zero_rail, b_one_rail,
               vec_width, shift_amount, shift_unknown, a_signed_negative,
        input  ready
    );

    modport sink (
        input  valid, action, a_zero_rail, a_one_rail, b_zero_rail, b_one_rail,
               vec_width, shift_amount, shift_unknown, a_signed_negative,
        output ready
    );
endinterface

@@ design/fslu_out_if.sv @@
interface fslu_out_if;
    logic                           valid;
    logic                           ready;
    logic [fslu_pkg::MAX_WIDTH-1:0] res_zero_rail;
    logic [fslu_pkg::MAX_WIDTH-1:0] res_one_rail;
    logic [fslu_pkg::SCALAR_W-1:0]  scalar_result;

    modport source (
        output valid, res_zero_rail, res_one_rail, scalar_result,
        input  ready
    );

    modport sink (
        input  valid, res_zero_rail, res_one_rail, scalar_result,
        output ready
    );
endinterface

@@ design/fslu_bitwise.sv @@
module fslu_bitwise (
    input  logic [fslu_pkg::ACTION_W-1:0]  action,
    input  fslu_pkg::rail_t                a,
    input  fslu_pkg::rail_t                b,
    input  logic [fslu_pkg::MAX_WIDTH-1:0] mask,
    output fslu_pkg::rail_t                res
);
    import fslu_pkg::*;

    logic [MAX_WIDTH-1:0] az;
    logic [MAX_WIDTH-1:0] bz;
    logic [MAX_WIDTH-1:0] p0;
    logic [MAX_WIDTH-1:0] p1;
    logic [MAX_WIDTH-1:0] q0;
    logic [MAX_WIDTH-1:0] q1;

    // z reads as x
    assign az = ~a.zero & ~a.one & mask;
    assign bz = ~b.zero & ~b.one & mask;
    assign p0 = a.zero | az;
    assign p1 = a.one  | az;
    assign q0 = b.zero | bz;
    assign q1 = b.one  | bz;

    always_comb
    begin
        res.zero = ALL_ZEROS;
        res.one  = ALL_ZEROS;
        case (action)
            ACT_NOT:
            begin
                res.zero = p1;
                res.one  = p0;
            end
            ACT_AND:
            begin
                res.zero = p0 | q0;
                res.one  = p1 & q1;
            end
            ACT_OR:
            begin
                res.zero = p0 & q0;
                res.one  = p1 | q1;
            end
            ACT_XOR:
            begin
                res.zero = (p0 | q1) & (p1 | q0);
                res.one  = (p1 & q0) | (p0 & q1);
            end
            ACT_MERGE:
            begin
                res.zero = p0 | q0;
                res.one  = p1 | q1;
            end
            default:
            begin
                res.zero = ALL_ZEROS;
                res.one  = ALL_ZEROS;
            end
        endcase
    end
endmodule

@@ design/fslu_reduce.sv @@
module fslu_reduce (
    input  logic [fslu_pkg::ACTION_W-1:0]  action,
    input  fslu_pkg::rail_t                a,
    input  logic [fslu_pkg::MAX_WIDTH-1:0] mask,
    output logic [fslu_pkg::SCALAR_W-1:0]  scalar
);
    import fslu_pkg::*;

    logic has_xz;
    logic v_and;
    logic v_or;
    logic v_xor;

    // operands are already masked; x and z both show equal rails
    assign has_xz = |(~(a.zero ^ a.one) & mask);
    assign v_and  = ~|a.zero;
    assign v_or   = |a.one;
    assign v_xor  = ^a.one;

    always_comb
    begin
        scalar = SC_ZERO;
        case (action)
            ACT_RAND:  scalar = has_xz ? SC_X : (v_and  ? SC_ONE : SC_ZERO);
            ACT_RNAND: scalar = has_xz ? SC_X : (!v_and ? SC_ONE : SC_ZERO);
            ACT_ROR:   scalar = has_xz ? SC_X : (v_or   ? SC_ONE : SC_ZERO);
            ACT_RNOR:  scalar = has_xz ? SC_X : (!v_or  ? SC_ONE : SC_ZERO);
            ACT_RXOR:  scalar = has_xz ? SC_X : (v_xor  ? SC_ONE : SC_ZERO);
            ACT_RXNOR: scalar = has_xz ? SC_X : (!v_xor ? SC_ONE : SC_ZERO);
            default:   scalar = SC_ZERO;
        endcase
    end
endmodule

@@ design/fslu_shift.sv @@
module fslu_shift (
    input  logic [fslu_pkg::ACTION_W-1:0]  action,
    input  fslu_pkg::rail_t                a,
    input  logic [fslu_pkg::MAX_WIDTH-1:0] mask,
    input  logic [fslu_pkg::WIDTH_W-1:0]   width,
    input  logic [fslu_pkg::WIDTH_W-1:0]   amount,
    input  logic                           amount_unknown,
    input  logic                           negative,
    output fslu_pkg::rail_t                res
);
    import fslu_pkg::*;

    logic                 ones_fill;
    logic [MAX_WIDTH-1:0] low_fill;
    logic [MAX_WIDTH-1:0] top_fill;

    assign ones_fill = (action == ACT_ASHR) && negative;
    assign low_fill  = ~(ALL_ONES << amount);
    assign top_fill  = mask & ~(mask >> amount);

    always_comb
    begin
        res.zero = ALL_ZEROS;
        res.one  = ALL_ZEROS;
        if (amount_unknown)
        begin
            res.zero = mask;
            res.one  = mask;
        end
        else if (amount >= width)
        begin
            res.zero = ones_fill ? ALL_ZEROS : mask;
            res.one  = ones_fill ? mask : ALL_ZEROS;
        end
        else if (action == ACT_SHL)
        begin
            res.zero = (a.zero << amount) | low_fill;
            res.one  = a.one << amount;
        end
        else
        begin
            res.zero = (a.zero >> amount) | (ones_fill ? ALL_ZEROS : top_fill);
            res.one  = (a.one  >> amount) | (ones_fill ? top_fill : ALL_ZEROS);
        end
    end
endmodule

@@ design/four_state_logic_unit.sv @@
// Pipeline: an accepted input word passes the input register, then the
// result register, whose valid flag marks the result word.
// Throughput: one word per cycle unless the output stalls; both registers advance
// when the result register is empty or being drained; the input one also when empty.
// Reset: rst_n asynchronous, active low; clears both valid flags only.
module four_state_logic_unit (
    input  logic       clk,
    input  logic       rst_n,
    fslu_in_if.sink    in_ch,
    fslu_out_if.source out_ch
);
    import fslu_pkg::*;

    // Input stage registers
    logic                 s1_valid_reg;
    logic [ACTION_W-1:0]  s1_action_reg;
    rail_t                s1_a_reg;
    rail_t                s1_b_reg;
    logic [WIDTH_W-1:0]   s1_width_reg;
    logic [WIDTH_W-1:0]   s1_amount_reg;
    logic                 s1_unknown_reg;
    logic                 s1_negative_reg;

    // Result stage registers
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    rail_t                s2_res_reg;
    rail_t                s2_res_next;
    logic [SCALAR_W-1:0]  s2_scalar_reg;
    logic [SCALAR_W-1:0]  s2_scalar_next;

    // Handshake: result register frees up when empty or being taken
    logic                 s2_advance;
    logic                 s1_advance;

    // Datapath
    logic [WIDTH_W-1:0]   width;
    logic [MAX_WIDTH-1:0] mask;
    rail_t                a_m;
    rail_t                b_m;
    rail_t                bit_res;
    rail_t                sh_res;
    logic [SCALAR_W-1:0]  red_res;

    assign s2_advance  = !s2_valid_reg || out_ch.ready;
    assign s1_advance  = !s1_valid_reg || s2_advance;
    assign in_ch.ready = s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_ch.valid)
        begin
            s1_action_reg   <= in_ch.action;
            s1_a_reg.zero   <= in_ch.a_zero_rail;
            s1_a_reg.one    <= in_ch.a_one_rail;
            s1_b_reg.zero   <= in_ch.b_zero_rail;
            s1_b_reg.one    <= in_ch.b_one_rail;
            s1_width_reg    <= in_ch.vec_width;
            s1_amount_reg   <= in_ch.shift_amount;
            s1_unknown_reg  <= in_ch.shift_unknown;
            s1_negative_reg <= in_ch.a_signed_negative;
        end
    end

    // Width clamped to 1..MAX_WIDTH; mask has one bit per valid position.
    // A shift by MAX_WIDTH yields zero, so the full width gives all ones.
    always_comb
    begin
        width = s1_width_reg;
        if (s1_width_reg == '0)
        begin
            width = WIDTH_W'(1);
        end
        else if (s1_width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            width = WIDTH_W'(MAX_WIDTH);
        end
    end

    assign mask     = ~(ALL_ONES << width);
    assign a_m.zero = s1_a_reg.zero & mask;
    assign a_m.one  = s1_a_reg.one  & mask;
    assign b_m.zero = s1_b_reg.zero & mask;
    assign b_m.one  = s1_b_reg.one  & mask;

    fslu_bitwise u_bitwise (
        .action (s1_action_reg),
        .a      (a_m),
        .b      (b_m),
        .mask   (mask),
        .res    (bit_res)
    );

    fslu_reduce u_reduce (
        .action (s1_action_reg),
        .a      (a_m),
        .mask   (mask),
        .scalar (red_res)
    );

    fslu_shift u_shift (
        .action         (s1_action_reg),
        .a              (a_m),
        .mask           (mask),
        .width          (width),
        .amount         (s1_amount_reg),
        .amount_unknown (s1_unknown_reg),
        .negative       (s1_negative_reg),
        .res            (sh_res)
    );

    // Pick the unit by action class; unused fields read zero, and
    // undefined actions give all-zero outputs.
    always_comb
    begin
        s2_res_next.zero = ALL_ZEROS;
        s2_res_next.one  = ALL_ZEROS;
        s2_scalar_next   = SC_ZERO;
        case (s1_action_reg)
            ACT_NOT, ACT_AND, ACT_OR, ACT_XOR, ACT_MERGE:
            begin
                s2_res_next.zero = bit_res.zero & mask;
                s2_res_next.one  = bit_res.one  & mask;
            end
            ACT_RAND, ACT_RNAND, ACT_ROR, ACT_RNOR, ACT_RXOR, ACT_RXNOR:
            begin
                s2_scalar_next = red_res;
            end
            ACT_SHL, ACT_SHR, ACT_ASHR:
            begin
                s2_res_next.zero = sh_res.zero & mask;
                s2_res_next.one  = sh_res.one  & mask;
            end
            default:
            begin
                s2_scalar_next = SC_ZERO;
            end
        endcase
    end

    assign s2_valid_next = s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_advance)
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance && s1_valid_reg)
        begin
            s2_res_reg    <= s2_res_next;
            s2_scalar_reg <= s2_scalar_next;
        end
    end

    assign out_ch.valid         = s2_valid_reg;
    assign out_ch.res_zero_rail = s2_res_reg.zero;
    assign out_ch.res_one_rail  = s2_res_reg.one;
    assign out_ch.scalar_result = s2_scalar_reg;
endmodule

@@ test/fslu_result_checker.sv @@
`timescale 1ns / 100ps

module fslu_result_checker (
    input  logic clk,
    input  logic rst_n,
    fslu_in_if   in_ch,
    fslu_out_if  out_ch,
    output int   fail_count,
    output int   pending,
    output int   checked
);
    import fslu_pkg::*;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        rail_t               a;
        rail_t               b;
        logic [WIDTH_W-1:0]  width;
        logic [WIDTH_W-1:0]  amount;
        logic                unknown;
        logic                negative;
    } op_word_t;

    typedef struct packed {
        rail_t               res;
        logic [SCALAR_W-1:0] scalar;
    } res_word_t;

    res_word_t predicted_results[$];
    int        errors  = 0;
    int        n_check = 0;

    // Dual-rail evaluation of one word; z reads as x on bitwise inputs.
    function automatic res_word_t eval_logic_op(op_word_t op);
        res_word_t            r;
        logic [MAX_WIDTH-1:0] m, a0, a1, b0, b1, az, bz, p0, p1, q0, q1, top_fill;
        int unsigned          w, s;
        logic                 bit_val, ones_fill;
        w = op.width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        s = op.amount;
        m  = ALL_ONES >> (MAX_WIDTH - w);
        a0 = op.a.zero & m;
        a1 = op.a.one & m;
        b0 = op.b.zero & m;
        b1 = op.b.one & m;
        az = ~a0 & ~a1 & m;
        bz = ~b0 & ~b1 & m;
        p0 = a0 | az;
        p1 = a1 | az;
        q0 = b0 | bz;
        q1 = b1 | bz;
        r.res.zero = ALL_ZEROS;
        r.res.one  = ALL_ZEROS;
        r.scalar   = SC_ZERO;
        ones_fill  = (op.action == ACT_ASHR) && op.negative;
        case (op.action)
            ACT_NOT:
            begin
                r.res.zero = p1;
                r.res.one  = p0;
            end
            ACT_AND:
            begin
                r.res.zero = p0 | q0;
                r.res.one  = p1 & q1;
            end
            ACT_OR:
            begin
                r.res.zero = p0 & q0;
                r.res.one  = p1 | q1;
            end
            ACT_XOR:
            begin
                r.res.zero = (p0 | q1) & (p1 | q0);
                r.res.one  = (p1 & q0) | (p0 & q1);
            end
            ACT_MERGE:
            begin
                r.res.zero = p0 | q0;
                r.res.one  = p1 | q1;
            end
            ACT_RAND, ACT_RNAND, ACT_ROR, ACT_RNOR, ACT_RXOR, ACT_RXNOR:
            begin
                if ((~(a0 ^ a1) & m) != ALL_ZEROS)
                begin
                    r.scalar = SC_X;
                end
                else
                begin
                    case (op.action)
                        ACT_RAND, ACT_RNAND: bit_val = (a0 == ALL_ZEROS);
                        ACT_ROR, ACT_RNOR:   bit_val = (a1 != ALL_ZEROS);
                        default:             bit_val = ^a1;
                    endcase
                    if (op.action == ACT_RNAND || op.action == ACT_RNOR ||
                        op.action == ACT_RXNOR)
                        bit_val = !bit_val;
                    r.scalar = bit_val ? SC_ONE : SC_ZERO;
                end
            end
            ACT_SHL, ACT_SHR, ACT_ASHR:
            begin
                if (op.unknown)
                begin
                    r.res.zero = m;
                    r.res.one  = m;
                end
                else if (s >= w)
                begin
                    r.res.zero = ones_fill ? ALL_ZEROS : m;
                    r.res.one  = ones_fill ? m : ALL_ZEROS;
                end
                else if (op.action == ACT_SHL)
                begin
                    r.res.zero = (a0 << s) | ((64'd1 << s) - 64'd1);
                    r.res.one  = a1 << s;
                end
                else
                begin
                    top_fill   = m & ~(m >> s);
                    r.res.zero = a0 >> s;
                    r.res.one  = a1 >> s;
                    if (ones_fill)
                        r.res.one = r.res.one | top_fill;
                    else
                        r.res.zero = r.res.zero | top_fill;
                end
            end
            default: ;
        endcase
        r.res.zero = r.res.zero & m;
        r.res.one  = r.res.one & m;
        return r;
    endfunction

    task automatic report_field(string field, logic [MAX_WIDTH-1:0] want,
                                logic [MAX_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        res_word_t want, got;
        op_word_t  op;
        if (rst_n)
        begin
            // results first: nothing accepted at this edge can come out at it
            if (out_ch.valid && out_ch.ready)
            begin
                got.res.zero = out_ch.res_zero_rail;
                got.res.one  = out_ch.res_one_rail;
                got.scalar   = out_ch.scalar_result;
                if (predicted_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result word: expected none, actual %h %h %0d",
                             $time, got.res.zero, got.res.one, got.scalar);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    n_check++;
                    report_field("res_zero_rail", want.res.zero, got.res.zero);
                    report_field("res_one_rail", want.res.one, got.res.one);
                    report_field("scalar_result", 64'(want.scalar), 64'(got.scalar));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                op.action   = in_ch.action;
                op.a.zero   = in_ch.a_zero_rail;
                op.a.one    = in_ch.a_one_rail;
                op.b.zero   = in_ch.b_zero_rail;
                op.b.one    = in_ch.b_one_rail;
                op.width    = in_ch.vec_width;
                op.amount   = in_ch.shift_amount;
                op.unknown  = in_ch.shift_unknown;
                op.negative = in_ch.a_signed_negative;
                predicted_results.push_back(eval_logic_op(op));
            end
            pending    <= predicted_results.size();
            fail_count <= errors;
            checked    <= n_check;
        end
    end

endmodule

@@ test/tb_four_state_logic_unit.sv @@
`timescale 1ns / 100ps

module tb_four_state_logic_unit;
    import fslu_pkg::*;

    // Run limit in cycles: ~530 words with random gaps between bursts and output
    // stalls that can run long in the coin-flip mode; this is many times over.
    localparam int LIMIT       = 200000;
    localparam int RANDOM_WORDS = 500;

    // Directed operand patterns: in every 16-bit group, bit i holds one of
    // the 16 pairings of a (bits 0,1 of i) and b (bits 2,3 of i) values.
    localparam logic [MAX_WIDTH-1:0] PAT_A0 = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [MAX_WIDTH-1:0] PAT_A1 = 64'hCCCC_CCCC_CCCC_CCCC;
    localparam logic [MAX_WIDTH-1:0] PAT_B0 = 64'hF0F0_F0F0_F0F0_F0F0;
    localparam logic [MAX_WIDTH-1:0] PAT_B1 = 64'hFF00_FF00_FF00_FF00;

    typedef enum logic [1:0] {
        DRAIN_FREE,     // always ready
        DRAIN_COIN,     // ready half the time
        DRAIN_PERIODIC, // ready on a periodic schedule from the cycle counter
        DRAIN_RARE      // rare random stalls
    } drain_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fslu_in_if  in_ch ();
    fslu_out_if out_ch ();

    four_state_logic_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    int fail_count, pending, checked;

    fslu_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Free-running cycle count; also the watchdog.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", LIMIT, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: ready follows a random mode that is held until its countdown
    // runs out, so stalls land on both pipeline stages and there are stall-free runs.
    logic        sink_ready  = 1'b0;
    drain_mode_e drain_mode  = DRAIN_FREE;
    int          drain_left  = 0;

    assign out_ch.ready = sink_ready;

    always @(posedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode <= drain_mode_e'($urandom_range(0, 3));
            drain_left <= $urandom_range(16, 96);
        end
        else
        begin
            drain_left <= drain_left - 1;
        end
        case (drain_mode)
            DRAIN_FREE:     sink_ready <= 1'b1;
            DRAIN_COIN:     sink_ready <= 1'($urandom_range(0, 1));
            DRAIN_PERIODIC: sink_ready <= (cycle_count % 4) == 0;
            default:        sink_ready <= $urandom_range(0, 7) != 0;
        endcase
    end

    // Input side bookkeeping
    int burst_left = 0;
    int n_sent = 0, n_directed = 0;
    int n_bitwise = 0, n_reduce = 0, n_shift = 0, n_undef = 0;

    // Cast an integer code to the action field type.
    function automatic logic [ACTION_W-1:0] ACT_ACTION(int code);
        return ACTION_W'(code);
    endfunction

    // Send one word. Words go out in bursts; between bursts valid drops
    // for a random gap. Waits for the handshake before returning.
    task automatic send_word(logic [ACTION_W-1:0] act, rail_t a, rail_t b,
                             logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] s,
                             logic unk, logic neg);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // mostly short bursts, sometimes a long unbroken stream
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        in_ch.valid             <= 1'b1;
        in_ch.action            <= act;
        in_ch.a_zero_rail       <= a.zero;
        in_ch.a_one_rail        <= a.one;
        in_ch.b_zero_rail       <= b.zero;
        in_ch.b_one_rail        <= b.one;
        in_ch.vec_width         <= w;
        in_ch.shift_amount      <= s;
        in_ch.shift_unknown     <= unk;
        in_ch.a_signed_negative <= neg;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
        n_sent++;
        if (act <= ACT_MERGE)
            n_bitwise++;
        else if (act <= ACT_RXNOR)
            n_reduce++;
        else if (act <= ACT_ASHR)
            n_shift++;
        else
            n_undef++;
    endtask

    // Fully known vector: zero rail is the complement of the one rail.
    function automatic rail_t known(logic [MAX_WIDTH-1:0] v);
        rail_t r;
        r.zero = ~v;
        r.one  = v;
        return r;
    endfunction

    // Random operand. Known vectors dominate so reductions return values,
    // not just x; some are fully random rails (lots of x and z) and some
    // are known with a few x or z bits dropped in.
    function automatic rail_t rand_operand();
        rail_t r;
        int    bit_pos;
        case ($urandom_range(0, 5))
            0:
            begin
                r.zero = {$urandom, $urandom};
                r.one  = {$urandom, $urandom};
            end
            3:
            begin
                r = known({$urandom, $urandom});
                repeat ($urandom_range(1, 3))
                begin
                    bit_pos = $urandom_range(0, MAX_WIDTH - 1);
                    r.zero[bit_pos] = 1'($urandom_range(0, 1));
                    r.one[bit_pos]  = r.zero[bit_pos];
                end
            end
            4:       r = known(ALL_ONES);
            5:       r = known(ALL_ZEROS);
            default: r = known({$urandom, $urandom});
        endcase
        return r;
    endfunction

    initial
    begin
        rail_t               pa, pb, zabove;
        logic [ACTION_W-1:0] act;
        logic [WIDTH_W-1:0]  w, s;
        int                  eff_w;

        in_ch.valid             <= 1'b0;
        in_ch.action            <= ACT_NOT;
        in_ch.a_zero_rail       <= ALL_ZEROS;
        in_ch.a_one_rail        <= ALL_ZEROS;
        in_ch.b_zero_rail       <= ALL_ZEROS;
        in_ch.b_one_rail        <= ALL_ZEROS;
        in_ch.vec_width         <= '0;
        in_ch.shift_amount      <= '0;
        in_ch.shift_unknown     <= 1'b0;
        in_ch.a_signed_negative <= 1'b0;

        pa.zero = PAT_A0;
        pa.one  = PAT_A1;
        pb.zero = PAT_B0;
        pb.one  = PAT_B1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed words ----
        // bitwise ops over every pairing of 0/1/x/z, full width
        for (int op = ACT_NOT; op <= ACT_MERGE; op++)
            send_word(ACT_ACTION(op), pa, pb, 7'd64, '0, 1'b0, 1'b0);
        // narrow width: the pattern above bit 12 must be ignored
        send_word(ACT_NOT, pa, pb, 7'd13, '0, 1'b0, 1'b0);
        send_word(ACT_MERGE, pa, pb, 7'd13, '0, 1'b0, 1'b0);
        // all six reductions over an all-ones vector
        for (int op = ACT_RAND; op <= ACT_RXNOR; op++)
            send_word(ACT_ACTION(op), known(ALL_ONES), pb, 7'd64, '0, 1'b0, 1'b0);
        send_word(ACT_RAND, known(ALL_ZEROS), pb, 7'd1, '0, 1'b0, 1'b0);
        send_word(ACT_RXOR, pa, pb, 7'd64, '0, 1'b0, 1'b0);
        // z above the width must not turn the reduction into x
        zabove = known(64'h5);
        zabove.zero[20] = 1'b0;
        zabove.one[20]  = 1'b0;
        send_word(ACT_ROR, zabove, pb, 7'd8, '0, 1'b0, 1'b0);
        // shifts: zero distance, width-1, signed fill both ways,
        // unknown amount, amount equal to width, out-of-range width and amount
        send_word(ACT_SHL, pa, pb, 7'd64, 7'd0, 1'b0, 1'b0);
        send_word(ACT_SHR, pa, pb, 7'd64, 7'd63, 1'b0, 1'b0);
        send_word(ACT_ASHR, pa, pb, 7'd40, 7'd5, 1'b0, 1'b1);
        send_word(ACT_ASHR, pa, pb, 7'd40, 7'd5, 1'b0, 1'b0);
        send_word(ACT_SHL, pa, pb, 7'd64, 7'd3, 1'b1, 1'b0);
        send_word(ACT_SHR, pa, pb, 7'd20, 7'd20, 1'b0, 1'b0);
        send_word(ACT_ASHR, pa, pb, 7'd127, 7'd127, 1'b0, 1'b1);
        send_word(ACT_SHL, pa, pb, 7'd0, 7'd0, 1'b0, 1'b0);
        // the two undefined action codes
        send_word(ACT_ACTION(int'(ACT_ASHR) + 1), pa, pb, 7'd64, 7'd1, 1'b1, 1'b1);
        send_word(ACT_ACTION((1 << ACTION_W) - 1), pa, pb, 7'd64, 7'd1, 1'b1, 1'b1);
        n_directed = n_sent;

        // ---- random words ----
        repeat (RANDOM_WORDS)
        begin
            if ($urandom_range(0, 31) != 0)
                act = ACT_ACTION($urandom_range(int'(ACT_NOT), int'(ACT_ASHR)));
            else
                act = ACT_ACTION($urandom_range(int'(ACT_ASHR) + 1, (1 << ACTION_W) - 1));
            // width: mostly legal, with the edges and out-of-range codes
            case ($urandom_range(0, 15))
                0:       w = '0;
                1:       w = WIDTH_W'($urandom_range(MAX_WIDTH + 1, (1 << WIDTH_W) - 1));
                2:       w = WIDTH_W'(MAX_WIDTH);
                3:       w = 7'd1;
                default: w = WIDTH_W'($urandom_range(1, MAX_WIDTH));
            endcase
            eff_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
            // amount: mostly up to the width (the fill boundary), sometimes anything
            if ($urandom_range(0, 3) == 0)
                s = WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1));
            else
                s = WIDTH_W'($urandom_range(0, eff_w));
            send_word(act, rand_operand(), rand_operand(), w, s,
                      $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        end
        in_ch.valid <= 1'b0;

        // let the checker see the last word, then drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // then keep running to catch stray results
        repeat (8) @(posedge clk);

        $display("Sent %0d words (%0d directed): %0d bitwise, %0d reductions, %0d shifts, %0d undefined.",
                 n_sent, n_directed, n_bitwise, n_reduce, n_shift, n_undef);
        $display("Checked %0d results with %0d mismatches.", checked, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
